FILE: src/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and widths for the barycentric coordinate pipeline
// Request and response structs, intermediate word widths and Q16.16 limits.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int CoordW = 32;                 // Q16.16 coordinate
  localparam int DiffW  = CoordW + 1;         // coordinate difference
  localparam int ProdW  = 2 * DiffW;          // product of two differences
  localparam int CrossW = ProdW + 1;          // cross product component
  localparam int HalfW  = 34;                 // low slice of a cross component
  localparam int HiW    = CrossW - HalfW;     // high slice, signed
  localparam int PartW  = 2 * HalfW;          // mixed partial product
  localparam int MulW   = 2 * CrossW;         // full product of two components
  localparam int DotW   = MulW + 2;           // sum of three products
  localparam int RemW   = DotW - 1;           // divider remainder
  localparam int FracW  = 16;                 // fraction bits of a weight
  localparam int QuotW  = 2 * FracW;          // quotient bits
  localparam int Lanes  = 3;                  // one lane per weight

  localparam logic [QuotW-1:0] QMax = {1'b0, {(QuotW-1){1'b1}}};
  localparam logic [QuotW-1:0] QMin = {1'b1, {(QuotW-1){1'b0}}};

  typedef struct packed {
    logic signed [CoordW-1:0] vertex_a_x;
    logic signed [CoordW-1:0] vertex_a_y;
    logic signed [CoordW-1:0] vertex_a_z;
    logic signed [CoordW-1:0] vertex_b_x;
    logic signed [CoordW-1:0] vertex_b_y;
    logic signed [CoordW-1:0] vertex_b_z;
    logic signed [CoordW-1:0] vertex_c_x;
    logic signed [CoordW-1:0] vertex_c_y;
    logic signed [CoordW-1:0] vertex_c_z;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } bcc_in_t;

  typedef struct packed {
    logic signed [QuotW-1:0] weight_a;
    logic signed [QuotW-1:0] weight_b;
    logic signed [QuotW-1:0] weight_c;
    logic                    degenerate;
  } bcc_out_t;

  typedef logic [CrossW-1:0] cross_word_t;
  typedef cross_word_t [2:0] vec3_t;
  // Index 0 is the normal, 1 to 3 are the sub-cross products for A, B, C.
  typedef vec3_t [3:0] vec_set_t;

  typedef logic [DotW-1:0] dot_word_t;
  typedef struct packed {
    dot_word_t             den;
    dot_word_t [Lanes-1:0] num;
  } dots_t;

endpackage

FILE: src/barycentric_coordinates_3d.sv
// Throughput: one request per cycle while the output buffer is not full;
// the 32-stage divider array sets the depth. A two-entry output buffer lets
// requests enter while a response waits; the whole pipeline holds only when
// that buffer is full.
// Reset clears all valid bits and the buffer; no clearing pass is needed.
// ----------------------------------------------------------------------------
// barycentric_coordinates_3d: barycentric weights of a point in a 3D triangle
// Cross products, dot products and a pipelined divider give Q16.16 weights.
// ----------------------------------------------------------------------------
module barycentric_coordinates_3d (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bcc_pkg::bcc_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bcc_pkg::bcc_out_t out_rsp_o
);
  import bcc_pkg::*;

  logic     en;
  logic     cross_valid;
  vec_set_t cross_vec;
  logic     dot_valid;
  dots_t    dots;
  logic     div_valid;
  bcc_out_t div_rsp;

  assign in_ready_o = en;

  bcc_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .req_i   (in_req_i),
    .valid_o (cross_valid),
    .cross_o (cross_vec)
  );

  bcc_dot u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cross_valid),
    .cross_i (cross_vec),
    .valid_o (dot_valid),
    .dots_o  (dots)
  );

  bcc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dot_valid),
    .dots_i  (dots),
    .valid_o (div_valid),
    .rsp_o   (div_rsp)
  );

  bcc_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .rsp_i   (div_rsp),
    .en_o    (en),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .rsp_o   (out_rsp_o)
  );

endmodule

FILE: src/bcc_cross.sv
// ----------------------------------------------------------------------------
// bcc_cross: differences and cross products
// Three stages: coordinate differences, 33x33 products, component subtraction.
// ----------------------------------------------------------------------------
module bcc_cross (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  bcc_pkg::bcc_in_t   req_i,
  output logic               valid_o,
  output bcc_pkg::vec_set_t  cross_o
);
  import bcc_pkg::*;

  // Operand pairs of the four cross products, by difference index:
  // 0 = B-A, 1 = C-A, 2 = P-A, 3 = P-B, 4 = P-C.
  localparam int unsigned USel [4] = '{0, 3, 2, 0};
  localparam int unsigned VSel [4] = '{1, 4, 1, 2};
  localparam int unsigned Nx1  [3] = '{1, 2, 0};
  localparam int unsigned Nx2  [3] = '{2, 0, 1};

  logic signed [CoordW-1:0] a_w [3];
  logic signed [CoordW-1:0] b_w [3];
  logic signed [CoordW-1:0] c_w [3];
  logic signed [CoordW-1:0] p_w [3];

  logic signed [DiffW-1:0] diff_d [5][3];
  logic signed [DiffW-1:0] diff_q [5][3];
  logic signed [ProdW-1:0] prod_d [4][3][2];
  logic signed [ProdW-1:0] prod_q [4][3][2];
  vec_set_t                cross_d;
  vec_set_t                cross_q;
  logic [2:0]              valid_q;

  always_comb begin
    a_w = '{req_i.vertex_a_x, req_i.vertex_a_y, req_i.vertex_a_z};
    b_w = '{req_i.vertex_b_x, req_i.vertex_b_y, req_i.vertex_b_z};
    c_w = '{req_i.vertex_c_x, req_i.vertex_c_y, req_i.vertex_c_z};
    p_w = '{req_i.point_x, req_i.point_y, req_i.point_z};
    for (int k = 0; k < 3; k++) begin
      diff_d[0][k] = DiffW'(b_w[k]) - DiffW'(a_w[k]);
      diff_d[1][k] = DiffW'(c_w[k]) - DiffW'(a_w[k]);
      diff_d[2][k] = DiffW'(p_w[k]) - DiffW'(a_w[k]);
      diff_d[3][k] = DiffW'(p_w[k]) - DiffW'(b_w[k]);
      diff_d[4][k] = DiffW'(p_w[k]) - DiffW'(c_w[k]);
    end
  end

  always_comb begin
    for (int s = 0; s < 4; s++) begin
      for (int k = 0; k < 3; k++) begin
        prod_d[s][k][0] = ProdW'(diff_q[USel[s]][Nx1[k]]) * ProdW'(diff_q[VSel[s]][Nx2[k]]);
        prod_d[s][k][1] = ProdW'(diff_q[USel[s]][Nx2[k]]) * ProdW'(diff_q[VSel[s]][Nx1[k]]);
        cross_d[s][k]   = CrossW'(prod_q[s][k][0]) - CrossW'(prod_q[s][k][1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q  <= diff_d;
      prod_q  <= prod_d;
      cross_q <= cross_d;
    end
  end

  assign valid_o = valid_q[2];
  assign cross_o = cross_q;

endmodule

FILE: src/bcc_dot.sv
// ----------------------------------------------------------------------------
// bcc_dot: dot products of the normal with itself and the sub-cross products
// Each 67x67 product is split into four products of 33- and 34-bit slices,
// recombined in the next stage and summed over three components after that.
// ----------------------------------------------------------------------------
module bcc_dot (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  bcc_pkg::vec_set_t  cross_i,
  output logic               valid_o,
  output bcc_pkg::dots_t     dots_o
);
  import bcc_pkg::*;

  logic [ProdW-1:0] hh_d [4][3];
  logic [ProdW-1:0] hh_q [4][3];
  logic [PartW-1:0] hl_d [4][3];
  logic [PartW-1:0] hl_q [4][3];
  logic [PartW-1:0] lh_d [4][3];
  logic [PartW-1:0] lh_q [4][3];
  logic [PartW-1:0] ll_d [4][3];
  logic [PartW-1:0] ll_q [4][3];
  logic [MulW-1:0]  prod_d [4][3];
  logic [MulW-1:0]  prod_q [4][3];
  logic [DotW-1:0]  dot_d [4];
  logic [DotW-1:0]  dot_q [4];
  logic [2:0]       valid_q;

  // Dot j pairs the normal with vector set j; j = 0 gives the denominator.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 3; k++) begin
        hh_d[j][k] = ProdW'($signed(cross_i[0][k][CrossW-1:HalfW]))
                   * ProdW'($signed(cross_i[j][k][CrossW-1:HalfW]));
        hl_d[j][k] = PartW'($signed(cross_i[0][k][CrossW-1:HalfW]))
                   * PartW'(cross_i[j][k][HalfW-1:0]);
        lh_d[j][k] = PartW'(cross_i[0][k][HalfW-1:0])
                   * PartW'($signed(cross_i[j][k][CrossW-1:HalfW]));
        ll_d[j][k] = PartW'(cross_i[0][k][HalfW-1:0]) * PartW'(cross_i[j][k][HalfW-1:0]);
        prod_d[j][k] = {hh_q[j][k], {(2*HalfW){1'b0}}}
                     + ((MulW'($signed(hl_q[j][k])) + MulW'($signed(lh_q[j][k]))) << HalfW)
                     + MulW'(ll_q[j][k]);
      end
      dot_d[j] = DotW'($signed(prod_q[j][0])) + DotW'($signed(prod_q[j][1]))
               + DotW'($signed(prod_q[j][2]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q   <= hh_d;
      hl_q   <= hl_d;
      lh_q   <= lh_d;
      ll_q   <= ll_d;
      prod_q <= prod_d;
      dot_q  <= dot_d;
    end
  end

  always_comb begin
    dots_o.den = dot_q[0];
    for (int i = 0; i < Lanes; i++) begin
      dots_o.num[i] = dot_q[i+1];
    end
  end

  assign valid_o = valid_q[2];

endmodule

FILE: src/bcc_div.sv
// ----------------------------------------------------------------------------
// bcc_div: pipelined restoring divider, three lanes sharing one denominator
// Magnitude and range check, then one quotient bit per stage, then the signed
// Q16.16 result with saturation and the degenerate override.
// ----------------------------------------------------------------------------
module bcc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  bcc_pkg::dots_t    dots_i,
  output logic              valid_o,
  output bcc_pkg::bcc_out_t rsp_o
);
  import bcc_pkg::*;

  typedef struct packed {
    logic             degenerate;
    logic [Lanes-1:0] neg;
    logic [Lanes-1:0] sat;
  } div_flags_t;

  // Prepare stage.
  logic [DotW-1:0]  mag_d [Lanes];
  logic [DotW-1:0]  mag_q [Lanes];
  logic [RemW-1:0]  den_q;
  logic             deg_q;
  logic [Lanes-1:0] neg_d;
  logic [Lanes-1:0] neg_q;
  logic             prep_valid_q;

  // Division stages; index 0 holds the initial partial remainder.
  logic [RemW-1:0]  rem_d [QuotW+1][Lanes];
  logic [RemW-1:0]  rem_q [QuotW+1][Lanes];
  logic [QuotW-1:0] lo_d  [QuotW+1][Lanes];
  logic [QuotW-1:0] lo_q  [QuotW+1][Lanes];
  logic [RemW-1:0]  dsr_q [QuotW+1];
  div_flags_t       flags_d;
  div_flags_t       flags_q [QuotW+1];
  logic [QuotW:0]   step_valid_q;

  logic [RemW-1:0]  trial [QuotW+1][Lanes];
  logic [QuotW:0]   mag33 [Lanes];
  logic [QuotW-1:0] weight [Lanes];
  bcc_out_t         rsp_d;
  bcc_out_t         rsp_q;
  logic             rsp_valid_q;

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      neg_d[i] = dots_i.num[i][DotW-1];
      mag_d[i] = neg_d[i] ? (DotW'(0) - dots_i.num[i]) : dots_i.num[i];
    end
  end

  // The remainder starts as the magnitude without its low fraction bits; those
  // bits, followed by zeros, feed the remainder one per stage. When the start
  // value already reaches the denominator the quotient is out of range.
  always_comb begin
    flags_d.degenerate = deg_q;
    flags_d.neg        = neg_q;
    for (int i = 0; i < Lanes; i++) begin
      rem_d[0][i]    = RemW'(mag_q[i][DotW-1:FracW]);
      lo_d[0][i]     = {mag_q[i][FracW-1:0], {FracW{1'b0}}};
      flags_d.sat[i] = RemW'(mag_q[i][DotW-1:FracW]) >= den_q;
    end
    for (int s = 1; s <= QuotW; s++) begin
      for (int i = 0; i < Lanes; i++) begin
        trial[s][i] = {rem_q[s-1][i][RemW-2:0], lo_q[s-1][i][QuotW-1]};
        if (trial[s][i] >= dsr_q[s-1]) begin
          rem_d[s][i] = trial[s][i] - dsr_q[s-1];
          lo_d[s][i]  = {lo_q[s-1][i][QuotW-2:0], 1'b1};
        end else begin
          rem_d[s][i] = trial[s][i];
          lo_d[s][i]  = {lo_q[s-1][i][QuotW-2:0], 1'b0};
        end
      end
    end
    for (int i = 0; i < Lanes; i++) begin
      trial[0][i] = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      mag33[i] = flags_q[QuotW].sat[i] ? {1'b1, {QuotW{1'b0}}} : {1'b0, lo_q[QuotW][i]};
      if (flags_q[QuotW].degenerate) begin
        weight[i] = '0;
      end else if (flags_q[QuotW].neg[i]) begin
        weight[i] = (mag33[i] > {1'b0, QMin}) ? QMin : (QuotW'(0) - mag33[i][QuotW-1:0]);
      end else begin
        weight[i] = (mag33[i] > {1'b0, QMax}) ? QMax : mag33[i][QuotW-1:0];
      end
    end
    rsp_d.weight_a   = weight[0];
    rsp_d.weight_b   = weight[1];
    rsp_d.weight_c   = weight[2];
    rsp_d.degenerate = flags_q[QuotW].degenerate;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
      step_valid_q <= '0;
      rsp_valid_q  <= 1'b0;
    end else if (en_i) begin
      prep_valid_q <= valid_i;
      step_valid_q <= {step_valid_q[QuotW-1:0], prep_valid_q};
      rsp_valid_q  <= step_valid_q[QuotW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q      <= mag_d;
      neg_q      <= neg_d;
      deg_q      <= (dots_i.den == '0);
      den_q      <= dots_i.den[RemW-1:0];
      rem_q      <= rem_d;
      lo_q       <= lo_d;
      dsr_q[0]   <= den_q;
      flags_q[0] <= flags_d;
      for (int s = 1; s <= QuotW; s++) begin
        dsr_q[s]   <= dsr_q[s-1];
        flags_q[s] <= flags_q[s-1];
      end
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = rsp_valid_q;
  assign rsp_o   = rsp_q;

endmodule

FILE: src/bcc_skid.sv
// ----------------------------------------------------------------------------
// bcc_skid: two-entry output buffer
// Holds finished responses so the pipeline keeps moving while the consumer
// stalls; the pipeline advances whenever the buffer is not full.
// ----------------------------------------------------------------------------
module bcc_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  bcc_pkg::bcc_out_t rsp_i,
  output logic              en_o,
  output logic              valid_o,
  input  logic              ready_i,
  output bcc_pkg::bcc_out_t rsp_o
);
  import bcc_pkg::*;

  bcc_out_t   mem_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;
  logic       push;
  logic       pop;

  assign en_o    = (cnt_q != 2'd2);
  assign push    = valid_i && en_o;
  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && ready_i;
  assign rsp_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= rsp_i;
    end
  end

endmodule
